>>> rtl/oni_pkg.sv
// Shared types, constants and helper functions for the octree insertion block.
package oni_pkg;

  localparam int MAX_LEVELS_DEF     = 5;
  localparam int OBJECT_ID_BITS_DEF = 16;

  // Fixed field widths
  localparam int COORD_W    = 32;  // signed Q16.16 coordinate
  localparam int EXT_W      = 31;  // unsigned Q15.16 extent / radius
  localparam int CENTER_W   = 34;  // node center, root plus all steps
  localparam int DELTA_W    = 35;  // sphere center minus node center
  localparam int DEPTH_W    = 3;
  localparam int ID_IN_W    = 16;
  localparam int NODE_OUT_W = 13;
  localparam int LEVEL_OUT_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIM = 3'd6;

  // Controls from the sequencer to the descent unit
  typedef struct packed {
    logic load;  // take a new item, start at the root
    logic step;  // move one level down
  } walk_ctrl_t;

  // Nodes in a complete octree of the given number of levels
  function automatic int node_count(input int levels);
    return ((8 ** levels) - 1) / 7;
  endfunction

  // Address width for a store of the given depth, at least one bit
  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

>>> rtl/oni_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module oni_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4681
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [oni_pkg::addr_width(DEPTH)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [oni_pkg::addr_width(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/oni_descent.sv
// Descent unit: per-level straddle test and child center update.
module oni_descent #(
  parameter int OBJECT_ID_BITS = oni_pkg::OBJECT_ID_BITS_DEF,
  parameter int NODE_W         = 13,
  parameter int LVL_W          = 3
) (
  input  logic                                clk,
  input  oni_pkg::walk_ctrl_t                 ctrl,
  input  logic signed [oni_pkg::COORD_W-1:0]  root_x,
  input  logic signed [oni_pkg::COORD_W-1:0]  root_y,
  input  logic signed [oni_pkg::COORD_W-1:0]  root_z,
  input  logic [oni_pkg::EXT_W-1:0]           half_x,
  input  logic [oni_pkg::EXT_W-1:0]           half_y,
  input  logic [oni_pkg::EXT_W-1:0]           half_z,
  input  logic [LVL_W-1:0]                    lim_in,
  input  logic [OBJECT_ID_BITS-1:0]           id_in,
  input  logic signed [oni_pkg::COORD_W-1:0]  sx_in,
  input  logic signed [oni_pkg::COORD_W-1:0]  sy_in,
  input  logic signed [oni_pkg::COORD_W-1:0]  sz_in,
  input  logic [oni_pkg::EXT_W-1:0]           radius_in,
  output logic                                stop,
  output logic [NODE_W-1:0]                   node,
  output logic [LVL_W-1:0]                    level,
  output logic [OBJECT_ID_BITS-1:0]           id
);

  localparam int CW = oni_pkg::CENTER_W;
  localparam int DW = oni_pkg::DELTA_W;

  // Item registers
  logic signed [oni_pkg::COORD_W-1:0] sph [3];
  logic signed [CW-1:0]               ctr [3];
  logic [oni_pkg::EXT_W-1:0]          hs  [3];   // half extent >> (level-1)
  logic [oni_pkg::EXT_W-1:0]          radius;
  logic [LVL_W-1:0]                   lim;

  logic signed [oni_pkg::COORD_W-1:0] root_a [3];
  logic [oni_pkg::EXT_W-1:0]          half_a [3];
  logic signed [DW-1:0]               delta  [3];
  logic [DW-1:0]                      mag    [3];
  logic signed [CW-1:0]               stp    [3];
  logic signed [CW-1:0]               ctr_next [3];
  logic [2:0]                         near;
  logic [2:0]                         oct;
  logic [NODE_W-1:0]                  node_next;

  always_comb begin
    root_a[0] = root_x;
    root_a[1] = root_y;
    root_a[2] = root_z;
    half_a[0] = half_x;
    half_a[1] = half_y;
    half_a[2] = half_z;
    for (int a = 0; a < 3; a++) begin
      delta[a]    = DW'(sph[a]) - DW'(ctr[a]);
      mag[a]      = delta[a][DW-1] ? DW'(-delta[a]) : DW'(delta[a]);
      near[a]     = (mag[a] <= DW'(radius));
      oct[a]      = !delta[a][DW-1] && (delta[a] != '0);
      stp[a]      = CW'(hs[a] >> 1);
      ctr_next[a] = oct[a] ? (ctr[a] + stp[a]) : (ctr[a] - stp[a]);
    end
    node_next = NODE_W'({node, oct} + 1'b1);
    stop      = (|near) || (level >= lim);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sph[0] <= sx_in;
      sph[1] <= sy_in;
      sph[2] <= sz_in;
      for (int a = 0; a < 3; a++) begin
        ctr[a] <= CW'(root_a[a]);
        hs[a]  <= half_a[a];
      end
      radius <= radius_in;
      lim    <= lim_in;
      id     <= id_in;
      node   <= '0;
      level  <= LVL_W'(1);
    end else if (ctrl.step) begin
      for (int a = 0; a < 3; a++) begin
        ctr[a] <= ctr_next[a];
        hs[a]  <= hs[a] >> 1;
      end
      node  <= node_next;
      level <= level + LVL_W'(1);
    end
  end

endmodule

>>> rtl/octree_object_node_insert.sv
// Top level of the octree object insertion block: config, sequencer, head table.
//
// Inserts one object, given by its bounding-sphere center and radius (Q16.16),
// into a complete implicit octree (root node 0 at level 1, children of node k
// at 8k+1..8k+8) and prepends it to the list of the node it lands in. Each
// accepted item walks down one level per clock in the descent unit, testing
// all three axes at once; the walk ends where the sphere straddles a node
// plane or at the depth limit. The list head of that node is then read from
// the head table RAM; the new head is written back, and the result register
// loaded, in the write-back state once that register is free. An item thus
// occupies the block from its input transfer through the descent and the
// RAM read to the write-back, where the next item can already be taken. One
// item is in flight at a time, so the read-modify-write of the table never
// overlaps another item. A result waiting in the output register does not
// block the descent; only the write-back cycle waits for the register to be
// free. After reset the head table is swept to empty, one entry per cycle
// over all node_count(MAX_LEVELS) entries (4681 at five levels), during which
// in_stall stays high; configuration writes are taken throughout. cfg_ready
// is always high. Configuration registers are to be written only while the
// block is idle; the user must keep to this, the block does not enforce it.
module octree_object_node_insert #(
  parameter int MAX_LEVELS     = oni_pkg::MAX_LEVELS_DEF,
  parameter int OBJECT_ID_BITS = oni_pkg::OBJECT_ID_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // config write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [oni_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [oni_pkg::CFG_DATA_W-1:0]         cfg_data,
  // input item channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [oni_pkg::ID_IN_W-1:0]            object_id,
  input  logic signed [oni_pkg::COORD_W-1:0]     sphere_x,
  input  logic signed [oni_pkg::COORD_W-1:0]     sphere_y,
  input  logic signed [oni_pkg::COORD_W-1:0]     sphere_z,
  input  logic [oni_pkg::EXT_W-1:0]              sphere_radius,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [oni_pkg::NODE_OUT_W-1:0]         target_node,
  output logic [oni_pkg::LEVEL_OUT_W-1:0]        target_level,
  output logic [oni_pkg::ID_IN_W-1:0]            prior_head,
  output logic                                   prior_head_valid
);

  localparam int NODE_COUNT = oni_pkg::node_count(MAX_LEVELS);
  localparam int NODE_W     = oni_pkg::addr_width(NODE_COUNT);
  localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
  localparam int ENTRY_W    = OBJECT_ID_BITS + 1;  // valid bit on top of the id
  localparam int CMP_W      = 4;                   // holds depth field and MAX_LEVELS

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,  // sweeping the head table empty
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,  // one level per cycle
    S_WRITE = 4'b1000   // head read back, write new head, load result
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic signed [oni_pkg::COORD_W-1:0] root_x, root_y, root_z;
  logic [oni_pkg::EXT_W-1:0]          half_x, half_y, half_z;
  logic [oni_pkg::DEPTH_W-1:0]        depth_limit;
  logic [LVL_W-1:0]                   lim_eff;

  // Clearing sweep
  logic [NODE_W-1:0] clr_cnt;
  logic              clr_last;

  // Descent unit
  oni_pkg::walk_ctrl_t         ctrl;
  logic                        stop;
  logic [NODE_W-1:0]           node;
  logic [LVL_W-1:0]            level;
  logic [OBJECT_ID_BITS-1:0]   id;

  // Head table
  logic               ram_we, ram_re;
  logic [NODE_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic out_free, write_go, in_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_x      <= '0;
      root_y      <= '0;
      root_z      <= '0;
      half_x      <= '0;
      half_y      <= '0;
      half_z      <= '0;
      depth_limit <= oni_pkg::DEPTH_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        oni_pkg::CFG_ROOT_X:    root_x      <= cfg_data;
        oni_pkg::CFG_ROOT_Y:    root_y      <= cfg_data;
        oni_pkg::CFG_ROOT_Z:    root_z      <= cfg_data;
        oni_pkg::CFG_HALF_X:    half_x      <= cfg_data[oni_pkg::EXT_W-1:0];
        oni_pkg::CFG_HALF_Y:    half_y      <= cfg_data[oni_pkg::EXT_W-1:0];
        oni_pkg::CFG_HALF_Z:    half_z      <= cfg_data[oni_pkg::EXT_W-1:0];
        oni_pkg::CFG_DEPTH_LIM: depth_limit <= cfg_data[oni_pkg::DEPTH_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Depth limit of zero acts as one; above the built depth it saturates
  always_comb begin
    priority if (depth_limit == '0) begin
      lim_eff = LVL_W'(1);
    end else if (CMP_W'(depth_limit) > CMP_W'(MAX_LEVELS)) begin
      lim_eff = LVL_W'(MAX_LEVELS);
    end else begin
      lim_eff = LVL_W'(depth_limit);
    end
  end

  // Handshake and sequencing
  assign out_free = !out_valid || !out_stall;
  assign write_go = (state == S_WRITE) && out_free;
  assign in_stall = !((state == S_IDLE) || write_go);
  assign in_xfer  = in_valid && !in_stall;
  assign clr_last = (clr_cnt == NODE_W'(NODE_COUNT - 1));

  always_comb begin
    ctrl.load  = in_xfer;
    ctrl.step  = (state == S_WALK) && !stop;
    ram_re     = (state == S_WALK) && stop;
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_last) state_next = S_IDLE;
      S_IDLE:  if (in_xfer) state_next = S_WALK;
      S_WALK:  if (stop) state_next = S_WRITE;
      S_WRITE: begin
        if (write_go) state_next = in_xfer ? S_WALK : S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + NODE_W'(1);
      end
    end
  end

  // Table write port: sweep after reset, otherwise the new list head
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = write_go;
      ram_waddr = node;
      ram_wdata = {1'b1, id};
    end
  end

  oni_descent #(
    .OBJECT_ID_BITS (OBJECT_ID_BITS),
    .NODE_W         (NODE_W),
    .LVL_W          (LVL_W)
  ) u_descent (
    .clk       (clk),
    .ctrl      (ctrl),
    .root_x    (root_x),
    .root_y    (root_y),
    .root_z    (root_z),
    .half_x    (half_x),
    .half_y    (half_y),
    .half_z    (half_z),
    .lim_in    (lim_eff),
    .id_in     (OBJECT_ID_BITS'(object_id)),
    .sx_in     (sphere_x),
    .sy_in     (sphere_y),
    .sz_in     (sphere_z),
    .radius_in (sphere_radius),
    .stop      (stop),
    .node      (node),
    .level     (level),
    .id        (id)
  );

  oni_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_head_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (node),
    .rd_data (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (write_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (write_go) begin
      target_node      <= oni_pkg::NODE_OUT_W'(node);
      target_level     <= oni_pkg::LEVEL_OUT_W'(level);
      prior_head       <= ram_rdata[OBJECT_ID_BITS] ?
                          oni_pkg::ID_IN_W'(ram_rdata[OBJECT_ID_BITS-1:0]) : '0;
      prior_head_valid <= ram_rdata[OBJECT_ID_BITS];
    end
  end

  // No input transfer while the table is being swept
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("input transfer during head table sweep");

  // An accepted item always starts a descent
  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_WALK))
    else $error("accepted item did not start a descent");

  // A fresh result only comes out of the write-back cycle
  a_result_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_WRITE))
    else $error("result appeared without a write-back");

  // Write-back waits while the held result is stalled
  a_write_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && out_valid && out_stall) |=> (state == S_WRITE))
    else $error("write-back overran a stalled result");

  // Table read is issued only at the end of a descent
  a_read_at_stop: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> (state == S_WRITE))
    else $error("head read outside descent end");

endmodule
